// ===== hw/rtl/gdau_pkg.sv =====
// ----------------------------------------------------------------------------
// gdau_pkg
// Shared types, constants and calendar tables of the Gregorian date unit.
// ----------------------------------------------------------------------------
package gdau_pkg;

    localparam int MAX_YEAR  = 9999;
    localparam int FIRST_DAY = 306;  // day number of 1 January of year 1

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int COUNT_W = 20;
    localparam int DIFF_W  = 23;
    localparam int ALU_W   = 24;
    localparam int ACC_W   = 23;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_SUB  = 2'd1,
        OP_DIFF = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    // Restoring division phases: 400-year eras, centuries, 4-year blocks, years.
    typedef enum logic [1:0] {
        PH_ERA  = 2'd0,
        PH_CENT = 2'd1,
        PH_QUAD = 2'd2,
        PH_YEAR = 2'd3
    } phase_t;

    typedef struct packed {
        logic [ALU_W-1:0] value;
        logic             cout;
    } alu_res_t;

    // Longest possible month length, February counted as 29.
    function automatic logic [4:0] month_days(input logic [3:0] m);
        logic [4:0] len;
        case (m)
            4'd2:    len = 5'd29;
            4'd4,
            4'd6,
            4'd9,
            4'd11:   len = 5'd30;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    // First day of each month in a year that starts on 1 March.
    function automatic logic [8:0] march_start(input logic [3:0] mp);
        logic [8:0] s;
        case (mp)
            4'd0:    s = 9'd0;
            4'd1:    s = 9'd31;
            4'd2:    s = 9'd61;
            4'd3:    s = 9'd92;
            4'd4:    s = 9'd122;
            4'd5:    s = 9'd153;
            4'd6:    s = 9'd184;
            4'd7:    s = 9'd214;
            4'd8:    s = 9'd245;
            4'd9:    s = 9'd275;
            4'd10:   s = 9'd306;
            4'd11:   s = 9'd337;
            default: s = 9'd0;
        endcase
        return s;
    endfunction

    // Month lengths in a year that starts on 1 March; February last.
    function automatic logic [4:0] march_len(input logic [3:0] mp);
        logic [4:0] len;
        case (mp)
            4'd1,
            4'd3,
            4'd6,
            4'd8:    len = 5'd30;
            4'd11:   len = 5'd29;
            default: len = 5'd31;
        endcase
        return len;
    endfunction

    function automatic logic [17:0] years_unit(input phase_t p);
        logic [17:0] u;
        case (p)
            PH_ERA:  u = 18'd400;
            PH_CENT: u = 18'd100;
            PH_QUAD: u = 18'd4;
            PH_YEAR: u = 18'd1;
            default: u = 18'd1;
        endcase
        return u;
    endfunction

    function automatic logic [17:0] days_unit(input phase_t p);
        logic [17:0] u;
        case (p)
            PH_ERA:  u = 18'd146097;
            PH_CENT: u = 18'd36524;
            PH_QUAD: u = 18'd1461;
            PH_YEAR: u = 18'd365;
            default: u = 18'd365;
        endcase
        return u;
    endfunction

    // Highest quotient bit of each phase.
    function automatic logic [2:0] phase_msb(input phase_t p);
        logic [2:0] k;
        case (p)
            PH_ERA:  k = 3'd5;
            PH_CENT: k = 3'd1;
            PH_QUAD: k = 3'd4;
            PH_YEAR: k = 3'd1;
            default: k = 3'd1;
        endcase
        return k;
    endfunction

endpackage

// ===== hw/rtl/gdau_alu.sv =====
// ----------------------------------------------------------------------------
// gdau_alu
// Shared add/subtract unit; carry out doubles as the "a >= b" flag.
// ----------------------------------------------------------------------------
module gdau_alu
    import gdau_pkg::*;
(
    input  logic [ALU_W-1:0] a,
    input  logic [ALU_W-1:0] b,
    input  logic             sub,
    output alu_res_t         res
);

    logic [ALU_W-1:0] b_eff;
    logic [ALU_W:0]   sum;

    assign b_eff = sub ? ~b : b;
    assign sum   = {1'b0, a} + {1'b0, b_eff} + {{ALU_W{1'b0}}, sub};

    assign res.value = sum[ALU_W-1:0];
    assign res.cout  = sum[ALU_W];

endmodule

// ===== hw/rtl/gdau_datechk.sv =====
// ----------------------------------------------------------------------------
// gdau_datechk
// Field check of a date; 29 February is let through for the leap test later.
// ----------------------------------------------------------------------------
module gdau_datechk
    import gdau_pkg::*;
(
    input  logic [YEAR_W-1:0]  year,
    input  logic [MONTH_W-1:0] month,
    input  logic [DAY_W-1:0]   day,
    output logic               ok
);

    assign ok = (year != '0) && (month != '0) && (month <= 4'd12) &&
                (day != '0) && (day <= month_days(month));

endmodule

// ===== hw/rtl/gregorian_date_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// gregorian_date_arithmetic_unit
// Gregorian date add, subtract and difference on a shared add/subtract unit.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears on
// the result ports for one cycle with done high, and must be taken then. Each
// date is converted to a day number by fifteen restoring divide steps of the
// year (eras, centuries, 4-year blocks, years), each on the single add/subtract
// unit, and one month step; the way back uses the same steps on the day
// number followed by a month walk of up to eleven steps. A date is rejected
// when a field is out of range at the request, or when 29 February meets a
// common year at a month step; an unused operation only raises done. busy
// falls in the cycle that shows the result, so the next request may be taken
// in that cycle.
module gregorian_date_arithmetic_unit
    import gdau_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic [1:0]               op,
    input  logic [YEAR_W-1:0]        year,
    input  logic [MONTH_W-1:0]       month,
    input  logic [DAY_W-1:0]         day,
    input  logic [COUNT_W-1:0]       day_count,
    input  logic [YEAR_W-1:0]        other_year,
    input  logic [MONTH_W-1:0]       other_month,
    input  logic [DAY_W-1:0]         other_day,
    output logic                     done,
    output logic [YEAR_W-1:0]        res_year,
    output logic [MONTH_W-1:0]       res_month,
    output logic [DAY_W-1:0]         res_day,
    output logic signed [DIFF_W-1:0] day_difference,
    output logic                     is_less,
    output logic                     is_equal,
    output logic                     input_invalid,
    output logic                     range_error
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV,
        S_MONTH_F,
        S_ADJ,
        S_MONTH_I,
        S_YEAR_I,
        S_DIFF
    } state_t;

    state_t               state_reg, state_next;
    phase_t               phase_reg, phase_next;
    logic [2:0]           k_reg, k_next;
    logic                 inv_reg, inv_next;
    logic                 sel_reg, sel_next;
    logic [ALU_W-1:0]     rem_reg, rem_next;
    logic [ACC_W-1:0]     acc_reg, acc_next;
    logic [ACC_W-1:0]     a_reg, a_next;
    logic [3:0]           q_reg, q_next;
    logic                 c3_reg, c3_next;
    logic                 q24_reg, q24_next;
    logic                 y3_reg, y3_next;
    logic [3:0]           mp_reg, mp_next;

    op_t                  op_reg, op_next;
    logic [MONTH_W-1:0]   m_reg, m_next;
    logic [DAY_W-1:0]     d_reg, d_next;
    logic [COUNT_W-1:0]   cnt_reg, cnt_next;
    logic [YEAR_W-1:0]    oy_reg, oy_next;
    logic [MONTH_W-1:0]   om_reg, om_next;
    logic [DAY_W-1:0]     od_reg, od_next;

    logic                 done_reg, done_next;
    logic [YEAR_W-1:0]    res_year_reg, res_year_next;
    logic [MONTH_W-1:0]   res_month_reg, res_month_next;
    logic [DAY_W-1:0]     res_day_reg, res_day_next;
    logic [DIFF_W-1:0]    diff_reg, diff_next;
    logic                 less_reg, less_next;
    logic                 equal_reg, equal_next;
    logic                 invalid_reg, invalid_next;
    logic                 rerr_reg, rerr_next;

    logic                 ok_p, ok_o;
    logic [ALU_W-1:0]     alu_a, alu_b;
    logic                 alu_sub;
    alu_res_t             alu_res;

    logic [ACC_W-1:0]     acc_add, acc_sum;
    logic [ACC_W-1:0]     div_sh, wt_sh;
    logic [MONTH_W-1:0]   cm;
    logic [DAY_W-1:0]     cd;
    logic [3:0]           mpf;
    logic [9:0]           offset;
    logic                 leap;
    logic [3:0]           mo;
    logic [YEAR_W-1:0]    sy;
    logic [MONTH_W-1:0]   sm;
    logic [YEAR_W-1:0]    ystart;
    logic [4:0]           q_shift;

    gdau_datechk u_chk_p (
        .year  (year),
        .month (month),
        .day   (day),
        .ok    (ok_p)
    );

    gdau_datechk u_chk_o (
        .year  (other_year),
        .month (other_month),
        .day   (other_day),
        .ok    (ok_o)
    );

    gdau_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .sub (alu_sub),
        .res (alu_res)
    );

    // Divisor and weight swap roles between date-to-days and days-to-date.
    assign div_sh = inv_reg ? (ACC_W'(days_unit(phase_reg)) << k_reg)
                            : (ACC_W'(years_unit(phase_reg)) << k_reg);
    assign wt_sh  = inv_reg ? (ACC_W'(years_unit(phase_reg)) << k_reg)
                            : (ACC_W'(days_unit(phase_reg)) << k_reg);

    assign cm = sel_reg ? om_reg : m_reg;
    assign cd = sel_reg ? od_reg : d_reg;

    assign mpf    = (cm >= 4'd3) ? (cm - 4'd3) : (cm + 4'd9);
    assign offset = {1'b0, march_start(mpf)} + {5'b0, cd} - 10'd1;

    // The year was decomposed after the March shift, so y is a leap year when
    // the shifted year sits last in its 4-year block, and not last in a
    // century unless also last in the era.
    assign leap = y3_reg && (!q24_reg || c3_reg);

    assign mo = (mp_reg < 4'd10) ? (mp_reg + 4'd3) : (mp_reg - 4'd9);

    // A forward pass starts on the primary date from idle, else on the second.
    assign sy     = (state_reg == S_IDLE) ? year : oy_reg;
    assign sm     = (state_reg == S_IDLE) ? month : om_reg;
    assign ystart = (sm <= 4'd2) ? (sy - 14'd1) : sy;

    always_comb
    begin
        case (state_reg)
            S_DIV:
            begin
                alu_a   = rem_reg;
                alu_b   = {1'b0, div_sh};
                alu_sub = 1'b1;
            end
            S_ADJ:
            begin
                alu_a   = rem_reg;
                alu_b   = {{(ALU_W-COUNT_W){1'b0}}, cnt_reg};
                alu_sub = (op_reg == OP_SUB);
            end
            S_MONTH_I:
            begin
                alu_a   = rem_reg;
                alu_b   = {{(ALU_W-5){1'b0}}, march_len(mp_reg)};
                alu_sub = 1'b1;
            end
            S_DIFF:
            begin
                alu_a   = {1'b0, a_reg};
                alu_b   = rem_reg;
                alu_sub = 1'b1;
            end
            default:
            begin
                alu_a   = rem_reg;
                alu_b   = '0;
                alu_sub = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            S_DIV:     acc_add = alu_res.cout ? wt_sh : '0;
            S_MONTH_F: acc_add = {{(ACC_W-10){1'b0}}, offset};
            S_YEAR_I:  acc_add = (mo <= 4'd2) ? ACC_W'(1) : '0;
            default:   acc_add = '0;
        endcase
    end

    assign acc_sum = acc_reg + acc_add;

    always_comb
    begin
        state_next     = state_reg;
        phase_next     = phase_reg;
        k_next         = k_reg;
        inv_next       = inv_reg;
        sel_next       = sel_reg;
        rem_next       = rem_reg;
        acc_next       = acc_reg;
        a_next         = a_reg;
        q_next         = q_reg;
        c3_next        = c3_reg;
        q24_next       = q24_reg;
        y3_next        = y3_reg;
        mp_next        = mp_reg;
        op_next        = op_reg;
        m_next         = m_reg;
        d_next         = d_reg;
        cnt_next       = cnt_reg;
        oy_next        = oy_reg;
        om_next        = om_reg;
        od_next        = od_reg;
        done_next      = 1'b0;
        res_year_next  = res_year_reg;
        res_month_next = res_month_reg;
        res_day_next   = res_day_reg;
        diff_next      = diff_reg;
        less_next      = less_reg;
        equal_next     = equal_reg;
        invalid_next   = invalid_reg;
        rerr_next      = rerr_reg;
        q_shift        = {q_reg, alu_res.cout};

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next        = op_t'(op);
                    m_next         = month;
                    d_next         = day;
                    cnt_next       = day_count;
                    oy_next        = other_year;
                    om_next        = other_month;
                    od_next        = other_day;
                    res_year_next  = '0;
                    res_month_next = 4'd1;
                    res_day_next   = 5'd1;
                    diff_next      = '0;
                    less_next      = 1'b0;
                    equal_next     = 1'b0;
                    invalid_next   = 1'b0;
                    rerr_next      = 1'b0;
                    if (op_t'(op) == OP_NONE)
                    begin
                        done_next = 1'b1;
                    end
                    else if (!ok_p || (op_t'(op) == OP_DIFF && !ok_o))
                    begin
                        invalid_next = 1'b1;
                        done_next    = 1'b1;
                    end
                    else
                    begin
                        rem_next   = {{(ALU_W-YEAR_W){1'b0}}, ystart};
                        acc_next   = '0;
                        phase_next = PH_ERA;
                        k_next     = phase_msb(PH_ERA);
                        inv_next   = 1'b0;
                        sel_next   = 1'b0;
                        q_next     = '0;
                        state_next = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                if (alu_res.cout)
                begin
                    rem_next = alu_res.value;
                end
                acc_next = acc_sum;
                q_next   = q_shift[3:0];
                if (k_reg == 3'd0)
                begin
                    if (!inv_reg)
                    begin
                        case (phase_reg)
                            PH_CENT: c3_next  = (q_shift[1:0] == 2'd3);
                            PH_QUAD: q24_next = (q_shift == 5'd24);
                            PH_YEAR: y3_next  = (q_shift[1:0] == 2'd3);
                            default: c3_next  = c3_reg;
                        endcase
                    end
                    q_next = '0;
                    if (phase_reg == PH_YEAR)
                    begin
                        mp_next    = '0;
                        state_next = inv_reg ? S_MONTH_I : S_MONTH_F;
                    end
                    else
                    begin
                        phase_next = phase_t'(phase_reg + 2'd1);
                        k_next     = phase_msb(phase_t'(phase_reg + 2'd1));
                    end
                end
                else
                begin
                    k_next = k_reg - 3'd1;
                end
            end

            S_MONTH_F:
            begin
                if (cm == 4'd2 && cd == 5'd29 && !leap)
                begin
                    invalid_next = 1'b1;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
                else if (op_reg == OP_DIFF && !sel_reg)
                begin
                    a_next     = acc_sum;
                    rem_next   = {{(ALU_W-YEAR_W){1'b0}}, ystart};
                    acc_next   = '0;
                    phase_next = PH_ERA;
                    k_next     = phase_msb(PH_ERA);
                    sel_next   = 1'b1;
                    q_next     = '0;
                    state_next = S_DIV;
                end
                else
                begin
                    rem_next   = {1'b0, acc_sum};
                    state_next = (op_reg == OP_DIFF) ? S_DIFF : S_ADJ;
                end
            end

            S_ADJ:
            begin
                // A subtract must neither borrow nor land before 1 January of year 1.
                if (op_reg == OP_SUB &&
                    (!alu_res.cout || alu_res.value < ALU_W'(FIRST_DAY)))
                begin
                    rerr_next  = 1'b1;
                    done_next  = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    rem_next   = alu_res.value;
                    acc_next   = '0;
                    phase_next = PH_ERA;
                    k_next     = phase_msb(PH_ERA);
                    inv_next   = 1'b1;
                    q_next     = '0;
                    state_next = S_DIV;
                end
            end

            S_MONTH_I:
            begin
                if (alu_res.cout && mp_reg != 4'd11)
                begin
                    rem_next = alu_res.value;
                    mp_next  = mp_reg + 4'd1;
                end
                else
                begin
                    state_next = S_YEAR_I;
                end
            end

            S_YEAR_I:
            begin
                if (acc_sum == '0 || acc_sum > ACC_W'(MAX_YEAR))
                begin
                    rerr_next = 1'b1;
                end
                else
                begin
                    res_year_next  = acc_sum[YEAR_W-1:0];
                    res_month_next = mo;
                    res_day_next   = rem_reg[DAY_W-1:0] + 5'd1;
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            S_DIFF:
            begin
                less_next  = !alu_res.cout;
                equal_next = (a_reg == rem_reg[ACC_W-1:0]);
                if (!alu_res.value[ALU_W-1] && alu_res.value[ALU_W-2])
                begin
                    diff_next = {1'b0, {(DIFF_W-1){1'b1}}};
                end
                else if (alu_res.value[ALU_W-1] && !alu_res.value[ALU_W-2])
                begin
                    diff_next = {1'b1, {(DIFF_W-1){1'b0}}};
                end
                else
                begin
                    diff_next = alu_res.value[DIFF_W-1:0];
                end
                done_next  = 1'b1;
                state_next = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            done_reg      <= 1'b0;
            phase_reg     <= PH_ERA;
            k_reg         <= '0;
            inv_reg       <= 1'b0;
            sel_reg       <= 1'b0;
            rem_reg       <= '0;
            acc_reg       <= '0;
            a_reg         <= '0;
            q_reg         <= '0;
            c3_reg        <= 1'b0;
            q24_reg       <= 1'b0;
            y3_reg        <= 1'b0;
            mp_reg        <= '0;
            op_reg        <= OP_ADD;
            m_reg         <= '0;
            d_reg         <= '0;
            cnt_reg       <= '0;
            oy_reg        <= '0;
            om_reg        <= '0;
            od_reg        <= '0;
            res_year_reg  <= '0;
            res_month_reg <= 4'd1;
            res_day_reg   <= 5'd1;
            diff_reg      <= '0;
            less_reg      <= 1'b0;
            equal_reg     <= 1'b0;
            invalid_reg   <= 1'b0;
            rerr_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            done_reg      <= done_next;
            phase_reg     <= phase_next;
            k_reg         <= k_next;
            inv_reg       <= inv_next;
            sel_reg       <= sel_next;
            rem_reg       <= rem_next;
            acc_reg       <= acc_next;
            a_reg         <= a_next;
            q_reg         <= q_next;
            c3_reg        <= c3_next;
            q24_reg       <= q24_next;
            y3_reg        <= y3_next;
            mp_reg        <= mp_next;
            op_reg        <= op_next;
            m_reg         <= m_next;
            d_reg         <= d_next;
            cnt_reg       <= cnt_next;
            oy_reg        <= oy_next;
            om_reg        <= om_next;
            od_reg        <= od_next;
            res_year_reg  <= res_year_next;
            res_month_reg <= res_month_next;
            res_day_reg   <= res_day_next;
            diff_reg      <= diff_next;
            less_reg      <= less_next;
            equal_reg     <= equal_next;
            invalid_reg   <= invalid_next;
            rerr_reg      <= rerr_next;
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign res_year       = res_year_reg;
    assign res_month      = res_month_reg;
    assign res_day        = res_day_reg;
    assign day_difference = diff_reg;
    assign is_less        = less_reg;
    assign is_equal       = equal_reg;
    assign input_invalid  = invalid_reg;
    assign range_error    = rerr_reg;

endmodule
